// File: src/fpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpd_pkg
// Shared types, register map and mode decoding for the field phase detector.
// ----------------------------------------------------------------------------
package fpd_pkg;

    localparam int ACC_W = 44;
    localparam int SUM_W = 43;
    localparam int TAP_SHIFT = 2;   // center tap gain of four

    // register indexes on the configuration port (byte address 4*index)
    localparam logic [1:0] REG_PHASE_MODE   = 2'd0;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

    localparam logic [11:0] WIDTH_RST  = 12'd720;
    localparam logic [11:0] HEIGHT_RST = 12'd480;

    typedef enum logic [3:0] {
        MODE_PROG      = 4'd0,
        MODE_TOP       = 4'd1,
        MODE_BOTTOM    = 4'd2,
        MODE_TOP_AN    = 4'd3,
        MODE_BOTTOM_AN = 4'd4,
        MODE_ANALYZE   = 4'd5,
        MODE_FULL_AN   = 4'd6,
        MODE_AUTO      = 4'd7,
        MODE_AUTO_AN   = 4'd8
    } t_mode;

    typedef enum logic [1:0] {
        PHASE_PROG   = 2'd0,
        PHASE_TOP    = 2'd1,
        PHASE_BOTTOM = 2'd2
    } t_phase;

    // per-pixel control carried from the counter stage down the pipeline
    typedef struct packed {
        t_mode      mode;
        logic       add_p;
        logic       add_t;
        logic       add_b;
        logic       toggle;
        logic       frame_end;
        logic [1:0] slot;
    } t_pix_ctrl;

    // resolve the auto modes from the frame flags; undefined codes are progressive
    function automatic t_mode eff_mode(input logic [3:0] mode, input logic inter,
                                       input logic topf);
        t_mode m;
        m = MODE_PROG;
        if (mode == MODE_AUTO) begin
            m = inter ? (topf ? MODE_TOP : MODE_BOTTOM) : MODE_PROG;
        end else if (mode == MODE_AUTO_AN) begin
            m = inter ? (topf ? MODE_TOP_AN : MODE_BOTTOM_AN) : MODE_FULL_AN;
        end else if (mode inside {[MODE_PROG:MODE_FULL_AN]}) begin
            m = t_mode'(mode);
        end
        return m;
    endfunction

    function automatic logic uses_prog(input t_mode m);
        return m inside {MODE_TOP_AN, MODE_BOTTOM_AN, MODE_FULL_AN};
    endfunction

    function automatic logic uses_top(input t_mode m);
        return m inside {MODE_TOP_AN, MODE_ANALYZE, MODE_FULL_AN};
    endfunction

    function automatic logic uses_bottom(input t_mode m);
        return m inside {MODE_BOTTOM_AN, MODE_ANALYZE, MODE_FULL_AN};
    endfunction

    function automatic logic is_fixed(input t_mode m);
        return m inside {MODE_PROG, MODE_TOP, MODE_BOTTOM};
    endfunction

endpackage
`default_nettype wire

// File: src/fpd_line_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpd_line_store
// Column-addressed line memory, one read and one write port, registered read.
// A write at the edge of a read to the same column is forwarded.
// ----------------------------------------------------------------------------
module fpd_line_store #(
    parameter int DEPTH = 2048,
    parameter int DATA_W = 48,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    output logic      [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic [DATA_W-1:0] r_fwd_data;
    logic              r_fwd_hit;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_rd_data;

endmodule
`default_nettype wire

// File: src/field_phase_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// field_phase_detector
// Telecine field phase detection over co-located luma of two frames.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one new/old pixel pair per
//   transfer in raster order; the flags are taken on a frame's first pixel.
//   Output channel (o_out_valid / i_out_stall) carries one result per frame,
//   produced by the frame's last pixel: phase and the three raw sums (zero in fixed modes).
//   Throughput is one pixel per cycle while o_in_stall is low. After the
//   transfer of the last pixel, a result passes line memory read and square,
//   accumulate and decide before it reaches the output register.
//   The line memory holds three lines of both frames per column in one word;
//   each pixel does one read and one write of that word.
//   Configuration goes through the APB-style port; write while no result is
//   pending. Reset clears counters and sums and loads mode auto_an, 720x480.
//   Line memory contents are not cleared and need no clearing pass.
//   While a result waits in the output register and the receiver stalls,
//   pixels keep flowing until another result reaches the last stage; then
//   the pipeline holds and o_in_stall rises.
// ----------------------------------------------------------------------------
module field_phase_detector #(
    parameter int PIXEL_BITS = 8,
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [PIXEL_BITS-1:0] i_new_pixel,
    input  wire logic [PIXEL_BITS-1:0] i_old_pixel,
    input  wire logic                  i_is_interlaced,
    input  wire logic                  i_field_order,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [1:0]                 o_phase,
    output logic [42:0]                o_top_sum,
    output logic [42:0]                o_bottom_sum,
    output logic [42:0]                o_prog_sum,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [3:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int PW2 = 2 * PIXEL_BITS;
    localparam int WORD_W = 3 * PW2;
    localparam int DW = PIXEL_BITS + 4;
    localparam int SQ_W = 2 * PIXEL_BITS + 5;
    localparam int ACC_W = fpd_pkg::ACC_W;
    localparam int SUM_W = fpd_pkg::SUM_W;

    // ---------------- configuration ----------------
    logic [3:0]  r_phase_mode;
    logic [11:0] r_frame_width;
    logic [11:0] r_frame_height;
    logic        cfg_write;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_mode   <= fpd_pkg::MODE_AUTO_AN;
            r_frame_width  <= fpd_pkg::WIDTH_RST;
            r_frame_height <= fpd_pkg::HEIGHT_RST;
        end else if (cfg_write) begin
            case (paddr[3:2])
                fpd_pkg::REG_PHASE_MODE:   r_phase_mode   <= pwdata[3:0];
                fpd_pkg::REG_FRAME_WIDTH:  r_frame_width  <= pwdata[11:0];
                fpd_pkg::REG_FRAME_HEIGHT: r_frame_height <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            fpd_pkg::REG_PHASE_MODE:   prdata = {28'd0, r_phase_mode};
            fpd_pkg::REG_FRAME_WIDTH:  prdata = {20'd0, r_frame_width};
            fpd_pkg::REG_FRAME_HEIGHT: prdata = {20'd0, r_frame_height};
            default:                   prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic en;
    logic in_accept;
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_s3_valid;
    logic r_out_valid;

    // hold everything only when a result cannot move into the output register
    assign en = !(r_s3_valid && r_out_valid && i_out_stall);
    assign o_in_stall = !en;
    assign in_accept = i_in_valid && en;

    // ---------------- stage 0: raster counters ----------------
    logic [AW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [1:0]    r_slot;
    logic          r_toggle;
    logic [1:0]    r_flags;     // {field_order, interlaced}

    logic [AW-1:0]      wm1;
    logic [RW-1:0]      hm1;
    logic               first_px;
    logic [1:0]         flags_now;
    fpd_pkg::t_mode     mode_now;
    logic               analyze;
    logic               line_end;
    logic               frame_end;
    fpd_pkg::t_pix_ctrl ctrl_now;

    always_comb begin
        if (r_frame_width == 12'd0) begin
            wm1 = '0;
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            wm1 = AW'(MAX_WIDTH - 1);
        end else begin
            wm1 = AW'(r_frame_width - 12'd1);
        end
        if (r_frame_height == 12'd0) begin
            hm1 = '0;
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            hm1 = RW'(MAX_HEIGHT - 1);
        end else begin
            hm1 = RW'(r_frame_height - 12'd1);
        end
    end

    always_comb begin
        first_px  = (r_row == '0) && (r_col == '0);
        flags_now = first_px ? {i_field_order, i_is_interlaced} : r_flags;
        mode_now  = fpd_pkg::eff_mode(r_phase_mode, flags_now[0], flags_now[1]);
        analyze   = (32'(r_row) >= 3) && (r_row <= hm1);
        line_end  = r_col >= wm1;
        frame_end = line_end && (r_row >= hm1);

        ctrl_now.mode      = mode_now;
        ctrl_now.add_p     = analyze && fpd_pkg::uses_prog(mode_now);
        ctrl_now.add_t     = analyze && fpd_pkg::uses_top(mode_now);
        ctrl_now.add_b     = analyze && fpd_pkg::uses_bottom(mode_now);
        ctrl_now.toggle    = r_toggle;
        ctrl_now.frame_end = frame_end;
        ctrl_now.slot      = r_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_slot   <= '0;
            r_toggle <= 1'b0;
            r_flags  <= '0;
        end else if (in_accept) begin
            r_flags <= flags_now;
            if (!line_end) begin
                r_col <= AW'(r_col + 1'b1);
            end else begin
                r_col <= '0;
                if (frame_end) begin
                    r_row    <= '0;
                    r_slot   <= '0;
                    r_toggle <= 1'b0;
                end else begin
                    r_row    <= RW'(r_row + 1'b1);
                    r_slot   <= (r_slot == 2'd2) ? 2'd0 : 2'(r_slot + 2'd1);
                    r_toggle <= r_toggle ^ (32'(r_row) >= 3);
                end
            end
        end
    end

    // ---------------- stage 1: line memory read-modify-write, taps ----------------
    fpd_pkg::t_pix_ctrl    r_s1_ctrl;
    logic [AW-1:0]         r_s1_col;
    logic [PIXEL_BITS-1:0] r_s1_new;
    logic [PIXEL_BITS-1:0] r_s1_old;
    logic [WORD_W-1:0]     rd_word;
    logic [WORD_W-1:0]     wr_word;
    logic                  wr_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_ctrl <= ctrl_now;
            r_s1_col  <= r_col;
            r_s1_new  <= i_new_pixel;
            r_s1_old  <= i_old_pixel;
        end
    end

    assign wr_en = r_s1_valid && en;

    fpd_line_store #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (WORD_W)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_accept),
        .i_rd_addr (r_col),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_col),
        .i_wr_data (wr_word),
        .o_rd_data (rd_word)
    );

    // lane s of the word holds {new, old} of the row kept in slot s
    logic [PIXEL_BITS-1:0] lane_new [3];
    logic [PIXEL_BITS-1:0] lane_old [3];
    logic [PIXEL_BITS-1:0] nm, n0, n1, om, o0, o1;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            lane_new[k] = rd_word[k*PW2 + PIXEL_BITS +: PIXEL_BITS];
            lane_old[k] = rd_word[k*PW2 +: PIXEL_BITS];
            if (r_s1_ctrl.slot == 2'(k)) begin
                wr_word[k*PW2 +: PW2] = {r_s1_new, r_s1_old};
            end else begin
                wr_word[k*PW2 +: PW2] = rd_word[k*PW2 +: PW2];
            end
        end
        // slot holds row y-1, slot+1 row y, slot+2 row y+1
        case (r_s1_ctrl.slot)
            2'd1: begin
                nm = lane_new[1]; n0 = lane_new[2]; n1 = lane_new[0];
                om = lane_old[1]; o0 = lane_old[2]; o1 = lane_old[0];
            end
            2'd2: begin
                nm = lane_new[2]; n0 = lane_new[0]; n1 = lane_new[1];
                om = lane_old[2]; o0 = lane_old[0]; o1 = lane_old[1];
            end
            default: begin
                nm = lane_new[0]; n0 = lane_new[1]; n1 = lane_new[2];
                om = lane_old[0]; o0 = lane_old[1]; o1 = lane_old[2];
            end
        endcase
    end

    function automatic logic signed [DW-1:0] ext(input logic [PIXEL_BITS-1:0] v);
        return $signed({{(DW-PIXEL_BITS){1'b0}}, v});
    endfunction

    function automatic logic signed [DW-1:0] tap(input logic [PIXEL_BITS-1:0] a0,
                                                 input logic [PIXEL_BITS-1:0] b1,
                                                 input logic [PIXEL_BITS-1:0] a2,
                                                 input logic [PIXEL_BITS-1:0] bm);
        return ((ext(a0) - ext(b1)) <<< fpd_pkg::TAP_SHIFT) + ext(a2) - ext(bm);
    endfunction

    logic signed [DW-1:0]   t_p, t_no, t_on, t_top, t_bot;
    logic signed [2*DW-1:0] prod_p, prod_t, prod_b;

    always_comb begin
        t_p    = tap(n0, n1, r_s1_new, nm);
        t_no   = tap(n0, o1, r_s1_new, om);
        t_on   = tap(o0, n1, r_s1_old, nm);
        t_top  = r_s1_ctrl.toggle ? t_no : t_on;
        t_bot  = r_s1_ctrl.toggle ? t_on : t_no;
        prod_p = t_p * t_p;
        prod_t = t_top * t_top;
        prod_b = t_bot * t_bot;
    end

    // ---------------- stage 2: accumulate ----------------
    fpd_pkg::t_pix_ctrl r_s2_ctrl;
    logic [SQ_W-1:0]    r_s2_sq_p, r_s2_sq_t, r_s2_sq_b;
    logic [ACC_W-1:0]   r_acc_p, r_acc_t, r_acc_b;
    logic [ACC_W-1:0]   n_acc_p, n_acc_t, n_acc_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_s2_ctrl <= r_s1_ctrl;
            r_s2_sq_p <= SQ_W'(prod_p);
            r_s2_sq_t <= SQ_W'(prod_t);
            r_s2_sq_b <= SQ_W'(prod_b);
        end
    end

    always_comb begin
        n_acc_p = r_acc_p + (r_s2_ctrl.add_p ? ACC_W'(r_s2_sq_p) : '0);
        n_acc_t = r_acc_t + (r_s2_ctrl.add_t ? ACC_W'(r_s2_sq_t) : '0);
        n_acc_b = r_acc_b + (r_s2_ctrl.add_b ? ACC_W'(r_s2_sq_b) : '0);
    end

    fpd_pkg::t_mode   r_s3_mode;
    logic [SUM_W-1:0] r_res_p, r_res_t, r_res_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_p    <= '0;
            r_acc_t    <= '0;
            r_acc_b    <= '0;
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s3_valid <= r_s2_valid && r_s2_ctrl.frame_end;
            if (r_s2_valid) begin
                if (r_s2_ctrl.frame_end) begin
                    r_acc_p <= '0;
                    r_acc_t <= '0;
                    r_acc_b <= '0;
                end else begin
                    r_acc_p <= n_acc_p;
                    r_acc_t <= n_acc_t;
                    r_acc_b <= n_acc_b;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s2_valid && r_s2_ctrl.frame_end) begin
            r_s3_mode <= r_s2_ctrl.mode;
            r_res_p   <= n_acc_p[SUM_W-1:0];
            r_res_t   <= n_acc_t[SUM_W-1:0];
            r_res_b   <= n_acc_b[SUM_W-1:0];
        end
    end

    // ---------------- stage 3: decide, output register ----------------
    fpd_pkg::t_phase  phase_sel;
    logic [SUM_W-1:0] sum_p, sum_t, sum_b;
    logic             use_p, use_t, use_b, b_ok, t_ok;

    always_comb begin
        use_p = fpd_pkg::uses_prog(r_s3_mode);
        use_t = fpd_pkg::uses_top(r_s3_mode);
        use_b = fpd_pkg::uses_bottom(r_s3_mode);
        b_ok  = use_b && (!use_p || (r_res_b < r_res_p)) && (!use_t || (r_res_b < r_res_t));
        t_ok  = use_t && (!use_p || (r_res_t < r_res_p)) && (!use_b || (r_res_t < r_res_b));
        if (fpd_pkg::is_fixed(r_s3_mode)) begin
            phase_sel = fpd_pkg::t_phase'(r_s3_mode[1:0]);
            sum_p = '0;
            sum_t = '0;
            sum_b = '0;
        end else begin
            // a tie for the smallest sum falls through to progressive
            phase_sel = b_ok ? fpd_pkg::PHASE_BOTTOM
                      : (t_ok ? fpd_pkg::PHASE_TOP : fpd_pkg::PHASE_PROG);
            sum_p = r_res_p;
            sum_t = r_res_t;
            sum_b = r_res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en && r_s3_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s3_valid) begin
            o_phase      <= phase_sel;
            o_top_sum    <= sum_t;
            o_bottom_sum <= sum_b;
            o_prog_sum   <= sum_p;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire
